### sv/websocket_frame_deframer_defines.svh
// assertion macros for the websocket deframer
// used by the top level; no other dependencies
`ifndef WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define WSD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deframer assertion failed");

// next-cycle implication, disabled in reset
`define WSD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer assertion failed");

`endif

### sv/wsd_pkg.sv
// shared types and constants for the websocket frame deframer
// no dependencies
`timescale 1ns / 1ps

package wsd_pkg;

  localparam int LENGTH_WIDTH_DEF = 64;

  localparam logic [3:0] OPC_BINARY     = 4'h2;
  localparam logic [6:0] LEN_EXT16      = 7'd126;
  localparam logic [6:0] LEN_EXT64      = 7'd127;
  localparam logic [3:0] EXT16_BYTES    = 4'd2;
  localparam logic [3:0] EXT64_BYTES    = 4'd8;
  localparam logic [2:0] MASK_KEY_BYTES = 3'd4;

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_MASK    = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_DRAIN   = 3'd5
  } phase_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       end_of_buffer;
  } in_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       byte_valid;
    logic       binary_frame;
    logic       last_byte;
    logic       truncated;
  } out_t;

  typedef struct packed {
    phase_t phase;
    logic   in_payload;
  } status_t;

endpackage

### sv/websocket_frame_deframer.sv
// websocket frame deframer: one received byte per transaction, unmasked payload out
// bytes pass the input register, then a single parse step, then the result register;
// throughput one byte per cycle while the result register is not held by out_stall
// bytes that produce no result pass through the input register and are dropped
// synchronous active-low reset returns the parser to the first header byte, no result pending
// depends on wsd_pkg, wsd_in_reg, wsd_parser, wsd_out_reg, websocket_frame_deframer_defines.svh
`timescale 1ns / 1ps

`include "websocket_frame_deframer_defines.svh"

module websocket_frame_deframer #(
  parameter int LENGTH_WIDTH = wsd_pkg::LENGTH_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  wsd_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output wsd_pkg::out_t out_data
);

  logic             item_valid;
  wsd_pkg::in_t     item;
  logic             advance;
  logic             res_valid;
  wsd_pkg::out_t    res;
  wsd_pkg::status_t status;
  logic             out_load;

  // the held byte moves on whenever the result register can take a result
  assign advance  = item_valid && (!out_valid || !out_stall);
  assign out_load = advance && res_valid;

  wsd_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  wsd_parser #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (advance),
    .item      (item),
    .res_valid (res_valid),
    .res       (res),
    .status    (status)
  );

  wsd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (out_load),
    .res       (res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // input side only backs up behind a stalled result
  `WSD_ASSERT_IMP(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)
  // a truncation always sends the parser back to header parsing
  `WSD_ASSERT_NXT(a_trunc_resync, clk, rst_n, out_load && res.truncated, status.phase == wsd_pkg::PH_HDR0)
  // payload bytes come only out of the payload phase
  `WSD_ASSERT_IMP(a_byte_phase, clk, rst_n, res_valid && res.byte_valid, status.in_payload)

endmodule

### sv/wsd_in_reg.sv
// input register stage of the deframer
// depends on wsd_pkg
`timescale 1ns / 1ps

module wsd_in_reg (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  wsd_pkg::in_t in_data,
  input  logic         advance,
  output logic         item_valid,
  output wsd_pkg::in_t item
);

  logic         valid_r, valid_nxt;
  wsd_pkg::in_t data_r;
  logic         load;

  assign in_stall = valid_r && !advance;
  assign load     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= in_data;
    end
  end

  assign item_valid = valid_r;
  assign item       = data_r;

endmodule

### sv/wsd_parser.sv
// frame header parser, length tracking and payload unmasking
// depends on wsd_pkg
`timescale 1ns / 1ps

module wsd_parser #(
  parameter int LENGTH_WIDTH = wsd_pkg::LENGTH_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_en,
  input  wsd_pkg::in_t     item,
  output logic             res_valid,
  output wsd_pkg::out_t    res,
  output wsd_pkg::status_t status
);

  wsd_pkg::phase_t         phase_r, phase_nxt;
  logic [3:0]              ext_r, ext_nxt;
  logic [LENGTH_WIDTH-1:0] rem_r, rem_nxt;
  logic [31:0]             mkey_r, mkey_nxt;
  logic [2:0]              mcnt_r, mcnt_nxt;
  logic [1:0]              kidx_r, kidx_nxt;
  logic                    masked_r, masked_nxt;
  logic                    binary_r, binary_nxt;

  logic       trunc_evt;
  logic       pay_evt;
  logic       pay_last;
  logic       pay_trunc;
  logic [7:0] pay_data;
  logic       len_done;
  logic       hdr_done;
  logic [7:0] b;
  logic       eob;
  logic [7:0] key_byte;

  assign b   = item.rx_byte;
  assign eob = item.end_of_buffer;

  always_comb begin
    case (kidx_r)
      2'd0:    key_byte = mkey_r[31:24];
      2'd1:    key_byte = mkey_r[23:16];
      2'd2:    key_byte = mkey_r[15:8];
      default: key_byte = mkey_r[7:0];
    endcase
  end

  // next state and datapath
  always_comb begin
    phase_nxt  = phase_r;
    ext_nxt    = ext_r;
    rem_nxt    = rem_r;
    mkey_nxt   = mkey_r;
    mcnt_nxt   = mcnt_r;
    kidx_nxt   = kidx_r;
    masked_nxt = masked_r;
    binary_nxt = binary_r;
    trunc_evt  = 1'b0;
    pay_evt    = 1'b0;
    pay_last   = 1'b0;
    pay_trunc  = 1'b0;
    pay_data   = b;
    len_done   = 1'b0;
    hdr_done   = 1'b0;

    unique case (phase_r)
      wsd_pkg::PH_HDR0: begin
        binary_nxt = (b[3:0] == wsd_pkg::OPC_BINARY);
        masked_nxt = 1'b0;
        rem_nxt    = '0;
        ext_nxt    = '0;
        mcnt_nxt   = '0;
        mkey_nxt   = '0;
        kidx_nxt   = '0;
        if (eob) begin
          trunc_evt = 1'b1;
        end else begin
          phase_nxt = wsd_pkg::PH_HDR1;
        end
      end
      wsd_pkg::PH_HDR1: begin
        masked_nxt = b[7];
        if (b[6:0] == wsd_pkg::LEN_EXT16 || b[6:0] == wsd_pkg::LEN_EXT64) begin
          ext_nxt = (b[6:0] == wsd_pkg::LEN_EXT16) ? wsd_pkg::EXT16_BYTES
                                                   : wsd_pkg::EXT64_BYTES;
          rem_nxt = '0;
          if (eob) begin
            trunc_evt = 1'b1;
            phase_nxt = wsd_pkg::PH_HDR0;
          end else begin
            phase_nxt = wsd_pkg::PH_EXTLEN;
          end
        end else begin
          rem_nxt  = {{(LENGTH_WIDTH-7){1'b0}}, b[6:0]};
          len_done = 1'b1;
        end
      end
      wsd_pkg::PH_EXTLEN: begin
        rem_nxt = {rem_r[LENGTH_WIDTH-9:0], b};
        ext_nxt = (ext_r != 4'd0) ? ext_r - 4'd1 : 4'd0;
        if (ext_nxt == 4'd0) begin
          len_done = 1'b1;
        end else if (eob) begin
          trunc_evt = 1'b1;
          phase_nxt = wsd_pkg::PH_HDR0;
        end
      end
      wsd_pkg::PH_MASK: begin
        mkey_nxt = {mkey_r[23:0], b};
        mcnt_nxt = mcnt_r + 3'd1;
        if (mcnt_nxt >= wsd_pkg::MASK_KEY_BYTES) begin
          hdr_done = 1'b1;
        end else if (eob) begin
          trunc_evt = 1'b1;
          phase_nxt = wsd_pkg::PH_HDR0;
        end
      end
      wsd_pkg::PH_PAYLOAD: begin
        pay_evt   = 1'b1;
        pay_data  = masked_r ? (b ^ key_byte) : b;
        kidx_nxt  = kidx_r + 2'd1;
        rem_nxt   = (rem_r != '0) ? rem_r - {{(LENGTH_WIDTH-1){1'b0}}, 1'b1} : '0;
        // remaining count of zero or one means this byte ends the payload
        pay_last  = (rem_r[LENGTH_WIDTH-1:1] == '0);
        pay_trunc = eob && !pay_last;
        if (pay_last) begin
          phase_nxt = eob ? wsd_pkg::PH_HDR0 : wsd_pkg::PH_DRAIN;
        end else if (eob) begin
          phase_nxt = wsd_pkg::PH_HDR0;
        end
      end
      default: begin
        if (eob) begin
          phase_nxt = wsd_pkg::PH_HDR0;
        end
      end
    endcase

    // length known: fetch mask key or finish header
    if (len_done) begin
      if (masked_nxt) begin
        mcnt_nxt = '0;
        mkey_nxt = '0;
        if (eob) begin
          trunc_evt = 1'b1;
          phase_nxt = wsd_pkg::PH_HDR0;
        end else begin
          phase_nxt = wsd_pkg::PH_MASK;
        end
      end else begin
        hdr_done = 1'b1;
      end
    end

    if (hdr_done) begin
      kidx_nxt = '0;
      if (rem_nxt == '0) begin
        phase_nxt = eob ? wsd_pkg::PH_HDR0 : wsd_pkg::PH_DRAIN;
      end else if (eob) begin
        trunc_evt = 1'b1;
        phase_nxt = wsd_pkg::PH_HDR0;
      end else begin
        phase_nxt = wsd_pkg::PH_PAYLOAD;
      end
    end
  end

  // result of this step
  always_comb begin
    res_valid        = trunc_evt || pay_evt;
    res.payload_byte = pay_evt ? pay_data : 8'h00;
    res.byte_valid   = pay_evt;
    res.binary_frame = binary_nxt;
    res.last_byte    = trunc_evt || pay_last || pay_trunc;
    res.truncated    = trunc_evt || pay_trunc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= wsd_pkg::PH_HDR0;
      ext_r    <= '0;
      rem_r    <= '0;
      mkey_r   <= '0;
      mcnt_r   <= '0;
      kidx_r   <= '0;
      masked_r <= 1'b0;
      binary_r <= 1'b0;
    end else if (step_en) begin
      phase_r  <= phase_nxt;
      ext_r    <= ext_nxt;
      rem_r    <= rem_nxt;
      mkey_r   <= mkey_nxt;
      mcnt_r   <= mcnt_nxt;
      kidx_r   <= kidx_nxt;
      masked_r <= masked_nxt;
      binary_r <= binary_nxt;
    end
  end

  assign status.phase      = phase_r;
  assign status.in_payload = (phase_r == wsd_pkg::PH_PAYLOAD);

endmodule

### sv/wsd_out_reg.sv
// result register of the deframer
// depends on wsd_pkg
`timescale 1ns / 1ps

module wsd_out_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  wsd_pkg::out_t res,
  output logic          out_valid,
  input  logic          out_stall,
  output wsd_pkg::out_t out_data
);

  logic          valid_r, valid_nxt;
  wsd_pkg::out_t data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule
